### rtl/rle_mirrored_sprite_blit_defines.svh
// Assertion helpers shared by the sprite blitter RTL.
// All of them sample on clk_i and are off while rst_ni is low.
`ifndef RLE_MIRRORED_SPRITE_BLIT_DEFINES_SVH
`define RLE_MIRRORED_SPRITE_BLIT_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent (sequence allowed).
`define RMSB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RMSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rmsb_pkg.sv
`timescale 1ns / 1ps

package rmsb_pkg;

  localparam int TableEntries = 256;
  localparam int TableIdxW    = 8;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 13;

  localparam logic [2:0] HeaderBytes = 3'd4;
  localparam logic [7:0] RunKey      = 8'hF8;

  typedef enum logic [CfgIdxW-1:0] {
    RegPitch,
    RegDestX,
    RegDestY,
    RegClipLeft,
    RegClipTop,
    RegClipRight,
    RegClipBottom
  } cfg_reg_e;

  typedef struct packed {
    logic                 action;
    logic [TableIdxW-1:0] table_index;
    logic [7:0]           data_byte;
    logic                 stream_start;
  } in_req_t;

  typedef struct packed {
    logic [23:0] dest_offset;
    logic [7:0]  pixel_value;
  } out_rsp_t;

endpackage

### rtl/rmsb_ram.sv
`timescale 1ns / 1ps

module rmsb_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rle_mirrored_sprite_blit.sv
`timescale 1ns / 1ps
// Mirrored run-length sprite blitter with color table remap.
// Request channel (in_valid_i / in_stall_o / in_req_i): action 0 writes one
// color table entry, action 1 feeds one compressed stream byte; stream_start
// marks the first of the four header bytes (width lo, width hi, two ignored).
// Result channel (out_valid_o / out_stall_i / out_rsp_o): one framebuffer
// write per opaque pixel that lands inside the clip window, at the mirrored
// column. Config port: cfg_we_i writes register cfg_idx_i; write only while
// the block is idle.
// Throughput: one request per cycle while the output side is not backed up. A
// transparent run that wraps over more than one row runs through the 8-step
// radix-2 divider and holds the request channel until the divider is done.
// Pipeline: two register stages (color table read and row/column sums, then
// the row * pitch multiply); out_valid_o rises once the result has passed
// both stages into the output register.
// When the receiver stalls, the output register holds its result and one
// more result waits in the multiply stage; requests keep flowing until that
// stage is full too. Reset clears stream state, the pipeline and restores
// register defaults (pitch 640, rest 0); the color table holds garbage until
// written, and no clearing pass is done.

`include "rle_mirrored_sprite_blit_defines.svh"

module rle_mirrored_sprite_blit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rmsb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rmsb_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rmsb_pkg::in_req_t             in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rmsb_pkg::out_rsp_t            out_rsp_o
);

  import rmsb_pkg::*;

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [7:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {9'd0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  // Configuration registers
  logic [12:0] pitch_q;
  logic [11:0] dest_x_q, dest_y_q, clip_l_q, clip_t_q, clip_r_q, clip_b_q;

  // Stream decode state
  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic [15:0] width_q, width_d;
  logic [15:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic        await_q, await_d;
  logic        done_q, done_d;

  // Radix-2 divider for long runs
  logic        div_busy_q, div_busy_d;
  logic [16:0] div_rem_q, div_rem_d;
  logic [22:0] div_dvs_q, div_dvs_d;
  logic [7:0]  div_quo_q, div_quo_d;
  logic [2:0]  div_cnt_q, div_cnt_d;

  // Multiply stage and output register
  logic        s1_valid_q, s1_valid_d;
  logic [16:0] s1_ysum_q, s1_xsum_q;
  logic        out_valid_q, out_valid_d;
  out_rsp_t    out_q;

  // Handshake
  logic in_acc, out_en, s1_adv, s1_free;

  assign out_en     = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_en;
  assign s1_free    = !s1_valid_q || out_en;
  assign in_stall_o = div_busy_q || !s1_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Decode working signals
  logic        is_byte;
  logic [2:0]  eff_hdr;
  logic [15:0] eff_width, eff_col, eff_row;
  logic        eff_await, eff_done;
  logic        adv_en;
  logic [7:0]  adv_n;
  logic [16:0] adv_sum, adv_diff;
  logic [15:0] mir_col, adv_row;
  logic        in_win, emit;
  logic [23:0] div_trial_a, div_trial_b, div_trial;
  logic        div_ge;
  logic [16:0] div_rem_nx;
  logic [7:0]  div_quo_nx;
  logic [15:0] div_row;

  assign is_byte   = in_acc && in_req_i.action;
  // A start clears the position before the byte is taken as header byte 0
  assign eff_hdr   = in_req_i.stream_start ? 3'd0  : hdr_cnt_q;
  assign eff_width = in_req_i.stream_start ? 16'd0 : width_q;
  assign eff_col   = in_req_i.stream_start ? 16'd0 : col_q;
  assign eff_row   = in_req_i.stream_start ? 16'd0 : row_q;
  assign eff_await = in_req_i.stream_start ? 1'b0  : await_q;
  assign eff_done  = in_req_i.stream_start ? 1'b0  : done_q;

  assign mir_col = eff_width - 16'd1 - eff_col;
  assign in_win  = (eff_row >= {4'd0, clip_t_q}) && (eff_row <= {4'd0, clip_b_q}) &&
                   (mir_col >= {4'd0, clip_l_q}) && (mir_col <= {4'd0, clip_r_q});

  assign adv_sum  = {1'b0, eff_col} + {9'd0, adv_n};
  assign adv_diff = adv_sum - {1'b0, eff_width};
  assign adv_row  = sat_add(eff_row, 8'd1);

  assign div_trial_a = {7'd0, div_rem_q};
  assign div_trial_b = {1'b0, div_dvs_q};
  assign div_ge      = div_trial_a >= div_trial_b;
  assign div_trial   = div_trial_a - div_trial_b;
  assign div_rem_nx  = div_ge ? div_trial[16:0] : div_rem_q;
  assign div_quo_nx  = {div_quo_q[6:0], div_ge};
  assign div_row     = sat_add(row_q, div_quo_nx);

  always_comb begin
    hdr_cnt_d  = hdr_cnt_q;
    width_d    = width_q;
    col_d      = col_q;
    row_d      = row_q;
    await_d    = await_q;
    done_d     = done_q;
    div_busy_d = div_busy_q;
    div_rem_d  = div_rem_q;
    div_dvs_d  = div_dvs_q;
    div_quo_d  = div_quo_q;
    div_cnt_d  = div_cnt_q;
    adv_en     = 1'b0;
    adv_n      = 8'd0;
    emit       = 1'b0;

    if (is_byte) begin
      hdr_cnt_d = eff_hdr;
      width_d   = eff_width;
      col_d     = eff_col;
      row_d     = eff_row;
      await_d   = eff_await;
      done_d    = eff_done;
      if (eff_hdr < HeaderBytes) begin
        if (eff_hdr == 3'd0) begin
          width_d = {8'd0, in_req_i.data_byte};
        end else if (eff_hdr == 3'd1) begin
          width_d = {in_req_i.data_byte, eff_width[7:0]};
        end
        hdr_cnt_d = eff_hdr + 3'd1;
        if (eff_hdr == HeaderBytes - 3'd1) begin
          done_d = eff_done || (eff_row > {4'd0, clip_b_q});
        end
      end else if (eff_done) begin
        // drop bytes past the window
      end else if (eff_await) begin
        await_d = 1'b0;
        adv_en  = 1'b1;
        adv_n   = in_req_i.data_byte;
      end else if (in_req_i.data_byte == RunKey) begin
        await_d = 1'b1;
      end else if (in_req_i.data_byte > RunKey) begin
        adv_en = 1'b1;
        adv_n  = 8'(9'd256 - {1'b0, in_req_i.data_byte});
      end else if (eff_width != 16'd0) begin
        emit   = in_win;
        adv_en = 1'b1;
        adv_n  = 8'd1;
      end

      if (adv_en && eff_width != 16'd0) begin
        if (adv_sum < {1'b0, eff_width}) begin
          col_d  = adv_sum[15:0];
          done_d = eff_row > {4'd0, clip_b_q};
        end else if (adv_diff < {1'b0, eff_width}) begin
          col_d  = adv_diff[15:0];
          row_d  = adv_row;
          done_d = adv_row > {4'd0, clip_b_q};
        end else begin
          // Several rows: hand off to the divider and hold requests
          div_busy_d = 1'b1;
          div_rem_d  = adv_sum;
          div_dvs_d  = {eff_width, 7'd0};
          div_quo_d  = 8'd0;
          div_cnt_d  = 3'd7;
        end
      end
    end

    if (div_busy_q) begin
      div_rem_d = div_rem_nx;
      div_quo_d = div_quo_nx;
      div_dvs_d = div_dvs_q >> 1;
      div_cnt_d = div_cnt_q - 3'd1;
      if (div_cnt_q == 3'd0) begin
        div_busy_d = 1'b0;
        col_d      = div_rem_nx[15:0];
        row_d      = div_row;
        done_d     = done_q || (div_row > {4'd0, clip_b_q});
      end
    end
  end

  // Color table: written by table requests, read for each emitted pixel.
  // A write and a read never come from the same request, and a write lands
  // at the edge before any later read, so no forwarding is needed.
  logic [7:0] tbl_rdata;

  rmsb_ram #(
    .Width (8),
    .Depth (TableEntries)
  ) u_color_table (
    .clk_i   (clk_i),
    .we_i    (in_acc && !in_req_i.action),
    .waddr_i (in_req_i.table_index),
    .wdata_i (in_req_i.data_byte),
    .re_i    (emit),
    .raddr_i (in_req_i.data_byte),
    .rdata_o (tbl_rdata)
  );

  // Row term times pitch, then add the column term
  logic [29:0] row_prod;
  logic [23:0] offset;

  assign row_prod = {13'd0, s1_ysum_q} * {17'd0, pitch_q};
  assign offset   = row_prod[23:0] + {7'd0, s1_xsum_q};

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (emit) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q     <= 13'd640;
      dest_x_q    <= '0;
      dest_y_q    <= '0;
      clip_l_q    <= '0;
      clip_t_q    <= '0;
      clip_r_q    <= '0;
      clip_b_q    <= '0;
      hdr_cnt_q   <= '0;
      width_q     <= '0;
      col_q       <= '0;
      row_q       <= '0;
      await_q     <= 1'b0;
      done_q      <= 1'b0;
      div_busy_q  <= 1'b0;
      div_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          RegPitch:      pitch_q  <= cfg_wdata_i;
          RegDestX:      dest_x_q <= cfg_wdata_i[11:0];
          RegDestY:      dest_y_q <= cfg_wdata_i[11:0];
          RegClipLeft:   clip_l_q <= cfg_wdata_i[11:0];
          RegClipTop:    clip_t_q <= cfg_wdata_i[11:0];
          RegClipRight:  clip_r_q <= cfg_wdata_i[11:0];
          RegClipBottom: clip_b_q <= cfg_wdata_i[11:0];
          default: ;
        endcase
      end
      hdr_cnt_q   <= hdr_cnt_d;
      width_q     <= width_d;
      col_q       <= col_d;
      row_q       <= row_d;
      await_q     <= await_d;
      done_q      <= done_d;
      div_busy_q  <= div_busy_d;
      div_cnt_q   <= div_cnt_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_rem_q <= div_rem_d;
    div_dvs_q <= div_dvs_d;
    div_quo_q <= div_quo_d;
    if (emit) begin
      s1_ysum_q <= {5'd0, dest_y_q} + {1'b0, eff_row};
      s1_xsum_q <= {5'd0, dest_x_q} + {1'b0, mir_col};
    end
    if (s1_adv) begin
      out_q.dest_offset <= offset;
      out_q.pixel_value <= tbl_rdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `RMSB_ASSERT_SAME(a_div_len, $rose(div_busy_q), ##8 !div_busy_q, "divider did not finish in 8 cycles")
  `RMSB_ASSERT_SAME(a_div_ctx, div_busy_q, (hdr_cnt_q == HeaderBytes) && !done_q, "divider busy outside pixel data")
  `RMSB_ASSERT_SAME(a_col_rng, (hdr_cnt_q == HeaderBytes) && (width_q != 16'd0) && !div_busy_q, col_q < width_q, "column outside bitmap width")
  `RMSB_ASSERT_NEXT(a_s1_hold, s1_valid_q && !out_en, s1_valid_q, "pending result lost in multiply stage")

endmodule
